### design/rtp_pkg.sv
// Shared types and constants for the recency table with pruning.
`default_nettype none

package rtp_pkg;

  localparam int unsigned DEPTH_DEF       = 32;
  localparam int unsigned KEY_W           = 64;
  localparam int unsigned STAMP_W         = 64;
  localparam int unsigned COUNT_W         = 6;
  localparam int unsigned CFG_W           = 6;
  localparam int unsigned ENTRY_W         = KEY_W + STAMP_W;
  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = CFG_W'(32);

  typedef enum logic [0:0] {
    OP_NOTICE = 1'b0,
    OP_PRUNE  = 1'b1
  } rtp_op_e;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_EVICTED  = 3'd3,
    ST_NONE     = 3'd4
  } rtp_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_N_SCAN,
    S_N_DONE,
    S_P_NONE,
    S_P_LOADI,
    S_P_GETI,
    S_P_RANK,
    S_P_PLACE,
    S_C_READ,
    S_C_STEP
  } rtp_state_e;

  typedef struct packed {
    rtp_status_e        status;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic               last;
  } rtp_result_t;

endpackage

`default_nettype wire

### design/rtp_ram.sv
// Simple dual-port synchronous RAM with one write and one registered read port.
`default_nettype none

module rtp_ram import rtp_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned WIDTH = ENTRY_W,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // The read data holds its value until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### design/rtp_seq.sv
// Sequencer: notice scan, rank computation for prune, and copy-back/evict pass.
`default_nettype none

module rtp_seq import rtp_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [0:0]          opcode_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [STAMP_W-1:0]  stamp_i,
  input  logic [CFG_W-1:0]    max_entries_i,
  input  logic                res_free_i,
  output logic                res_push_o,
  output rtp_result_t         res_o,
  // Table memory
  output logic                m_wr_en_o,
  output logic [AW-1:0]       m_wr_addr_o,
  output logic [ENTRY_W-1:0]  m_wr_data_o,
  output logic                m_rd_en_o,
  output logic [AW-1:0]       m_rd_addr_o,
  input  logic [ENTRY_W-1:0]  m_rd_data_i,
  // Rank-ordered buffer memory
  output logic                b_wr_en_o,
  output logic [AW-1:0]       b_wr_addr_o,
  output logic [ENTRY_W-1:0]  b_wr_data_o,
  output logic                b_rd_en_o,
  output logic [AW-1:0]       b_rd_addr_o,
  input  logic [ENTRY_W-1:0]  b_rd_data_i
);

  localparam int unsigned MW = (CW > CFG_W) ? CW : CFG_W;

  rtp_state_e          state_q, state_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [STAMP_W-1:0]  stamp_q, stamp_d;
  logic [CW-1:0]       occ_q, occ_d;
  logic [CW-1:0]       j_q, j_d;
  logic [CW-1:0]       i_q, i_d;
  logic [CW-1:0]       r_q, r_d;
  logic [AW-1:0]       cmp_idx_q, cmp_idx_d;
  logic                data_vld_q, data_vld_d;
  logic                hit_q, hit_d;
  logic [AW-1:0]       hit_idx_q, hit_idx_d;
  logic [AW-1:0]       rank_q, rank_d;
  logic [KEY_W-1:0]    ikey_q, ikey_d;
  logic [STAMP_W-1:0]  istamp_q, istamp_d;

  logic [KEY_W-1:0]    m_key;
  logic [STAMP_W-1:0]  m_stamp;
  logic                accept;
  logic                key_match;
  logic                newer;
  logic                scan_end;
  logic                prune_needed;
  logic                i_last;
  logic                r_keep;
  logic                r_last;

  assign m_key   = m_rd_data_i[ENTRY_W-1:STAMP_W];
  assign m_stamp = m_rd_data_i[STAMP_W-1:0];

  assign accept       = in_valid_i && (state_q == S_IDLE);
  assign key_match    = data_vld_q && (m_key == key_q);
  // Another entry ranks ahead on a strictly newer stamp, or an equal one in a lower slot.
  assign newer        = data_vld_q && ((m_stamp > istamp_q) ||
                        ((m_stamp == istamp_q) && (cmp_idx_q < i_q[AW-1:0])));
  assign scan_end     = (j_q == occ_q);
  assign prune_needed = MW'(occ_q) > MW'(max_entries_i);
  assign i_last       = (i_q + CW'(1)) == occ_q;
  assign r_keep       = MW'(r_q) < MW'(max_entries_i);
  assign r_last       = (r_q + CW'(1)) == occ_q;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (rtp_op_e'(opcode_i) == OP_NOTICE) begin
            state_d = S_N_SCAN;
          end else if (prune_needed) begin
            state_d = S_P_LOADI;
          end else begin
            state_d = S_P_NONE;
          end
        end
      end
      S_N_SCAN: begin
        if (key_match || scan_end) begin
          state_d = S_N_DONE;
        end
      end
      S_N_DONE, S_P_NONE: begin
        if (res_free_i) begin
          state_d = S_IDLE;
        end
      end
      S_P_LOADI: state_d = S_P_GETI;
      S_P_GETI:  state_d = S_P_RANK;
      S_P_RANK: begin
        if (scan_end) begin
          state_d = S_P_PLACE;
        end
      end
      S_P_PLACE: begin
        state_d = i_last ? S_C_READ : S_P_LOADI;
      end
      S_C_READ: state_d = S_C_STEP;
      S_C_STEP: begin
        if (r_keep || res_free_i) begin
          state_d = r_last ? S_IDLE : S_C_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    key_d       = key_q;
    stamp_d     = stamp_q;
    occ_d       = occ_q;
    j_d         = j_q;
    i_d         = i_q;
    r_d         = r_q;
    cmp_idx_d   = cmp_idx_q;
    data_vld_d  = data_vld_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    rank_d      = rank_q;
    ikey_d      = ikey_q;
    istamp_d    = istamp_q;
    m_wr_en_o   = 1'b0;
    m_wr_addr_o = '0;
    m_wr_data_o = {key_q, stamp_q};
    m_rd_en_o   = 1'b0;
    m_rd_addr_o = j_q[AW-1:0];
    b_wr_en_o   = 1'b0;
    b_wr_addr_o = rank_q;
    b_wr_data_o = {ikey_q, istamp_q};
    b_rd_en_o   = 1'b0;
    b_rd_addr_o = r_q[AW-1:0];
    res_push_o  = 1'b0;
    res_o       = '{status: ST_NONE, key: '0, count: COUNT_W'(occ_q), last: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d      = key_i;
          stamp_d    = stamp_i;
          j_d        = '0;
          i_d        = '0;
          r_d        = '0;
          data_vld_d = 1'b0;
          hit_d      = 1'b0;
        end
      end
      S_N_SCAN: begin
        if (key_match) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
        end else if (!scan_end) begin
          m_rd_en_o  = 1'b1;
          cmp_idx_d  = j_q[AW-1:0];
          data_vld_d = 1'b1;
          j_d        = j_q + CW'(1);
        end
      end
      S_N_DONE: begin
        if (res_free_i) begin
          res_push_o = 1'b1;
          if (hit_q) begin
            m_wr_en_o    = 1'b1;
            m_wr_addr_o  = hit_idx_q;
            res_o.status = ST_UPDATED;
          end else if (occ_q != CW'(DEPTH)) begin
            m_wr_en_o    = 1'b1;
            m_wr_addr_o  = occ_q[AW-1:0];
            occ_d        = occ_q + CW'(1);
            res_o.status = ST_INSERTED;
            res_o.count  = COUNT_W'(occ_q + CW'(1));
          end else begin
            res_o.status = ST_DROPPED;
          end
        end
      end
      S_P_NONE: begin
        res_push_o = res_free_i;
      end
      S_P_LOADI: begin
        m_rd_en_o   = 1'b1;
        m_rd_addr_o = i_q[AW-1:0];
      end
      S_P_GETI: begin
        ikey_d     = m_key;
        istamp_d   = m_stamp;
        rank_d     = '0;
        j_d        = '0;
        data_vld_d = 1'b0;
      end
      S_P_RANK: begin
        if (newer) begin
          rank_d = rank_q + AW'(1);
        end
        if (!scan_end) begin
          m_rd_en_o  = 1'b1;
          cmp_idx_d  = j_q[AW-1:0];
          data_vld_d = 1'b1;
          j_d        = j_q + CW'(1);
        end else begin
          data_vld_d = 1'b0;
        end
      end
      S_P_PLACE: begin
        b_wr_en_o = 1'b1;
        i_d       = i_q + CW'(1);
      end
      S_C_READ: begin
        b_rd_en_o = 1'b1;
      end
      S_C_STEP: begin
        res_o.count = COUNT_W'(max_entries_i);
        res_o.last  = r_last;
        if (r_keep) begin
          m_wr_en_o   = 1'b1;
          m_wr_addr_o = r_q[AW-1:0];
          m_wr_data_o = b_rd_data_i;
        end else if (res_free_i) begin
          res_push_o   = 1'b1;
          res_o.status = ST_EVICTED;
          res_o.key    = b_rd_data_i[ENTRY_W-1:STAMP_W];
        end
        if (r_keep || res_free_i) begin
          r_d = r_q + CW'(1);
          if (r_last) begin
            occ_d = CW'(max_entries_i);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      occ_q      <= '0;
      data_vld_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      occ_q      <= occ_d;
      data_vld_q <= data_vld_d;
      hit_q      <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    stamp_q   <= stamp_d;
    j_q       <= j_d;
    i_q       <= i_d;
    r_q       <= r_d;
    cmp_idx_q <= cmp_idx_d;
    hit_idx_q <= hit_idx_d;
    rank_q    <= rank_d;
    ikey_q    <= ikey_d;
    istamp_q  <= istamp_d;
  end

endmodule

`default_nettype wire

### design/recency_table_with_pruning.sv
// Top level of the recency table with pruning: memories, sequencer, config and output registers.
`default_nettype none

// The block holds up to DEPTH keys, each with the stamp at which it was last noticed, in a
// synchronous table memory. A notice transaction scans the occupied slots one per cycle,
// refreshing a matching entry or appending a new one, and yields one result (updated,
// inserted or dropped when full). A prune transaction with nothing to evict yields a
// single "none" result. Otherwise each of the n occupied entries is ranked by a full pass
// over the table through the single read port and written to a second memory at its
// rank; a final pass over the ranks copies the kept entries back to slots 0 upwards and
// emits the evicted keys from newest to oldest, the last one flagged. One transaction is
// in progress at a time; a finished result waits in the output register while the next
// input transaction may be taken. The max_entries register (reset 32) is written through
// its own channel and should only be changed while the block is idle.
module recency_table_with_pruning import rtp_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_W-1:0]    cfg_max_entries_i,
  // Input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [0:0]          opcode_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [STAMP_W-1:0]  stamp_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [KEY_W-1:0]    evicted_key_o,
  output logic [COUNT_W-1:0]  entry_count_o,
  output logic                last_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [CFG_W-1:0]   max_entries_q;
  logic               out_valid_q;
  rtp_result_t        out_q;
  logic               res_free;
  logic               res_push;
  rtp_result_t        res;

  logic               m_wr_en;
  logic [AW-1:0]      m_wr_addr;
  logic [ENTRY_W-1:0] m_wr_data;
  logic               m_rd_en;
  logic [AW-1:0]      m_rd_addr;
  logic [ENTRY_W-1:0] m_rd_data;
  logic               b_wr_en;
  logic [AW-1:0]      b_wr_addr;
  logic [ENTRY_W-1:0] b_wr_data;
  logic               b_rd_en;
  logic [AW-1:0]      b_rd_addr;
  logic [ENTRY_W-1:0] b_rd_data;

  // The register write is always taken at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MAX_ENTRIES_RST;
    end else if (cfg_valid_i) begin
      max_entries_q <= cfg_max_entries_i;
    end
  end

  // Table memory: key in the upper half of each word, stamp in the lower.
  rtp_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ENTRY_W)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (m_wr_en),
    .wr_addr_i (m_wr_addr),
    .wr_data_i (m_wr_data),
    .rd_en_i   (m_rd_en),
    .rd_addr_i (m_rd_addr),
    .rd_data_o (m_rd_data)
  );

  // Rank-ordered copy of the table, built during a prune.
  rtp_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ENTRY_W)
  ) u_rank_buf (
    .clk_i     (clk_i),
    .wr_en_i   (b_wr_en),
    .wr_addr_i (b_wr_addr),
    .wr_data_i (b_wr_data),
    .rd_en_i   (b_rd_en),
    .rd_addr_i (b_rd_addr),
    .rd_data_o (b_rd_data)
  );

  rtp_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .key_i         (key_i),
    .stamp_i       (stamp_i),
    .max_entries_i (max_entries_q),
    .res_free_i    (res_free),
    .res_push_o    (res_push),
    .res_o         (res),
    .m_wr_en_o     (m_wr_en),
    .m_wr_addr_o   (m_wr_addr),
    .m_wr_data_o   (m_wr_data),
    .m_rd_en_o     (m_rd_en),
    .m_rd_addr_o   (m_rd_addr),
    .m_rd_data_i   (m_rd_data),
    .b_wr_en_o     (b_wr_en),
    .b_wr_addr_o   (b_wr_addr),
    .b_wr_data_o   (b_wr_data),
    .b_rd_en_o     (b_rd_en),
    .b_rd_addr_o   (b_rd_addr),
    .b_rd_data_i   (b_rd_data)
  );

  // The output register can take a new result when it is empty or being drained.
  assign res_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign evicted_key_o = out_q.key;
  assign entry_count_o = out_q.count;
  assign last_o        = out_q.last;

  // Once a transaction is accepted the block is busy for at least the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again straight after an accepted transaction");

  // Only evicted-key results carry a key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_EVICTED)) |-> (evicted_key_o == '0))
    else $error("non-zero key on a result that is not an eviction");

  // Every result other than an eviction is the only, hence last, one of its transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_EVICTED)) |-> last_o)
    else $error("single result without its last flag");

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the recency table with pruning.
`timescale 1ns / 1ps

module testbench;
  import rtp_pkg::*;

  localparam int unsigned SLOTS         = DEPTH_DEF;
  // A short quiet spell once the last owed result has been taken.
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES   = 400;

  // Every input of the block has a known value from time zero.
  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                cfg_valid_i       = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_max_entries_i = '0;
  logic                in_valid_i        = 1'b0;
  logic                in_ready_o;
  logic [0:0]          opcode_i          = OP_NOTICE;
  logic [KEY_W-1:0]    key_i             = '0;
  logic [STAMP_W-1:0]  stamp_i           = '0;
  logic                out_valid_o;
  logic                out_ready_i       = 1'b0;
  logic [2:0]          status_o;
  logic [KEY_W-1:0]    evicted_key_o;
  logic [COUNT_W-1:0]  entry_count_o;
  logic                last_o;

  // Shadow copy of the table and of the max_entries register, updated as each
  // transaction is accepted.
  logic [KEY_W-1:0]    mirror_keys   [SLOTS];
  logic [STAMP_W-1:0]  mirror_stamps [SLOTS];
  int                  mirror_fill = 0;
  int                  mirror_keep = 32;

  // Results still owed by the block, oldest first.
  rtp_result_t         replies_due [$];

  int  fail_count    = 0;
  int  notices_sent  = 0;
  int  prunes_sent   = 0;
  int  inserts_seen  = 0;
  int  updates_seen  = 0;
  int  drops_seen    = 0;
  int  evictions     = 0;
  int  empty_prunes  = 0;
  int  configs_done  = 0;

  // Idling controls. The receiver flag and the hold request are only changed just
  // after a rising edge, so the receiver process reads them cleanly at the falling edge.
  bit  sender_gaps_on   = 1'b1;
  bit  receiver_gaps_on = 1'b1;
  int  hold_requests    = 0;
  int  holds_begun      = 0;
  int  hold_left        = 0;

  recency_table_with_pruning uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_max_entries_i (cfg_max_entries_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .key_i             (key_i),
    .stamp_i           (stamp_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .evicted_key_o     (evicted_key_o),
    .entry_count_o     (entry_count_o),
    .last_o            (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The result receiver. A requested hold keeps ready low for a long stretch, counted
  // here; otherwise ready is dropped at random in about a third of the cycles, unless
  // the steady phase has switched idling off.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (holds_begun != hold_requests) begin
      holds_begun <= holds_begun + 1;
      hold_left   <= HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !receiver_gaps_on || ($urandom_range(99) >= 33);
    end
  end

  // Each result transaction is compared with the oldest outstanding expectation. The
  // outputs are sampled at the rising edge, before the block's own updates land.
  always @(posedge clk_i) begin
    rtp_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (replies_due.size() == 0) begin
        $error("unexpected result: status %0d key %h count %0d last %0d",
               status_o, evicted_key_o, entry_count_o, last_o);
        fail_count++;
      end else begin
        want = replies_due.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (evicted_key_o !== want.key) begin
          $error("evicted_key: expected %h, got %h", want.key, evicted_key_o);
          fail_count++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // Appends one owed result behind those already queued.
  function automatic void owe_result(input rtp_result_t r);
    replies_due = {replies_due, r};
  endfunction

  // Applies one accepted transaction to the shadow table and queues the results that
  // the block owes for it.
  task automatic mirror_apply(input rtp_op_e op, input logic [KEY_W-1:0] key,
                              input logic [STAMP_W-1:0] stamp);
    logic [KEY_W-1:0]   rank_key   [SLOTS];
    logic [STAMP_W-1:0] rank_stamp [SLOTS];
    rtp_result_t        r;
    int                 slot;
    int                 pos;
    int                 hit;
    hit = -1;
    if (op == OP_NOTICE) begin
      notices_sent++;
      for (slot = 0; slot < mirror_fill; slot++)
        if (hit < 0 && mirror_keys[slot] == key) hit = slot;
      r.key  = '0;
      r.last = 1'b1;
      if (hit >= 0) begin
        // A known key only has its stamp refreshed; it keeps its slot.
        mirror_stamps[hit] = stamp;
        r.status = ST_UPDATED;
        updates_seen++;
      end else if (mirror_fill < SLOTS) begin
        mirror_keys[mirror_fill]   = key;
        mirror_stamps[mirror_fill] = stamp;
        mirror_fill++;
        r.status = ST_INSERTED;
        inserts_seen++;
      end else begin
        // A new key on a full table is turned away and nothing changes.
        r.status = ST_DROPPED;
        drops_seen++;
      end
      r.count = COUNT_W'(mirror_fill);
      owe_result(r);
    end else if (mirror_fill <= mirror_keep) begin
      prunes_sent++;
      empty_prunes++;
      r = '{status: ST_NONE, key: '0, count: COUNT_W'(mirror_fill), last: 1'b1};
      owe_result(r);
    end else begin
      prunes_sent++;
      // Stable insertion sort, newest first. An entry only overtakes strictly older
      // ones, so on equal stamps the lower slot stays ahead.
      for (slot = 0; slot < mirror_fill; slot++) begin
        pos = slot;
        while (pos > 0 && rank_stamp[pos-1] < mirror_stamps[slot]) begin
          rank_key[pos]   = rank_key[pos-1];
          rank_stamp[pos] = rank_stamp[pos-1];
          pos--;
        end
        rank_key[pos]   = mirror_keys[slot];
        rank_stamp[pos] = mirror_stamps[slot];
      end
      for (slot = 0; slot < mirror_keep; slot++) begin
        mirror_keys[slot]   = rank_key[slot];
        mirror_stamps[slot] = rank_stamp[slot];
      end
      // The evicted keys leave from newest to oldest, each carrying the new occupancy.
      for (slot = mirror_keep; slot < mirror_fill; slot++) begin
        r = '{status: ST_EVICTED, key: rank_key[slot], count: COUNT_W'(mirror_keep),
              last: (slot == mirror_fill - 1)};
        owe_result(r);
        evictions++;
      end
      mirror_fill = mirror_keep;
    end
  endtask

  // Offers one transaction on the input channel. It is entered and left at a falling
  // edge; valid is left high so that back-to-back transactions need no second
  // assignment in the same step.
  task automatic offer_item(input rtp_op_e op, input logic [KEY_W-1:0] key,
                            input logic [STAMP_W-1:0] stamp);
    while (sender_gaps_on && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    key_i      <= key;
    stamp_i    <= stamp;
    do @(posedge clk_i); while (!in_ready_o);
    mirror_apply(op, key, stamp);
    @(negedge clk_i);
  endtask

  // Stops offering, waits for every owed result, then lets the block finish any
  // trailing internal work.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes max_entries. Only called once the block is idle.
  task automatic write_max_entries(input logic [CFG_W-1:0] value);
    cfg_valid_i       <= 1'b1;
    cfg_max_entries_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror_keep = int'(value);
    configs_done++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_steady(input bit on);
    @(posedge clk_i);
    sender_gaps_on   = !on;
    receiver_gaps_on = !on;
    @(negedge clk_i);
  endtask

  // Keys already held in four tries of ten (if any are held), so that refreshes are common,
  // small keys in one of ten and the rest spread over the whole 64-bit range.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll < 4 && mirror_fill > 0) return mirror_keys[$urandom_range(mirror_fill - 1)];
    if (roll == 4) return KEY_W'($urandom_range(15));
    return {$urandom, $urandom};
  endfunction

  // Small stamps make ties frequent, so the lower-slot-wins rule is exercised.
  function automatic logic [STAMP_W-1:0] pick_stamp();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll < 3) return STAMP_W'($urandom_range(7));
    if (roll == 3) return '0;
    if (roll == 4) return '1;
    return {$urandom, $urandom};
  endfunction

  // Field extremes, both operations, refreshes, stamp ties, prunes on an empty table,
  // prunes that keep everything and prunes that evict some or all entries.
  task automatic test_directed();
    offer_item(OP_PRUNE, '1, '1);
    offer_item(OP_NOTICE, '0, '0);
    offer_item(OP_NOTICE, '1, '1);
    offer_item(OP_NOTICE, '0, 64'h5555_5555_5555_5555);
    offer_item(OP_NOTICE, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    offer_item(OP_NOTICE, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
    offer_item(OP_NOTICE, 64'h1, 64'h5555_5555_5555_5555);
    offer_item(OP_NOTICE, 64'h8000_0000_0000_0000, 64'h1);
    offer_item(OP_NOTICE, '1, '0);
    offer_item(OP_PRUNE, '0, '0);
    wait_idle();
    write_max_entries(CFG_W'(63));
    offer_item(OP_PRUNE, 64'h1234, 64'h5678);
    wait_idle();
    write_max_entries(CFG_W'(2));
    offer_item(OP_PRUNE, '0, '0);
    offer_item(OP_NOTICE, 64'd42, 64'hAAAA_AAAA_AAAA_AAAA);
    offer_item(OP_NOTICE, 64'd43, 64'd7);
    wait_idle();
    write_max_entries(CFG_W'(0));
    offer_item(OP_PRUNE, '0, '0);
    offer_item(OP_PRUNE, '0, '0);
  endtask

  // Fills every slot, shows a new key being dropped and a known one still refreshed,
  // then evicts the whole table in one prune: the largest burst of results.
  task automatic test_full_table();
    wait_idle();
    write_max_entries(CFG_W'(32));
    while (mirror_fill < SLOTS)
      offer_item(OP_NOTICE, {$urandom, $urandom}, pick_stamp());
    offer_item(OP_NOTICE, {$urandom, $urandom}, pick_stamp());
    offer_item(OP_NOTICE, mirror_keys[$urandom_range(SLOTS - 1)], pick_stamp());
    offer_item(OP_PRUNE, '0, '0);
    wait_idle();
    write_max_entries(CFG_W'(0));
    offer_item(OP_PRUNE, '0, '0);
  endtask

  // Random traffic in phases, each with its own max_entries setting. One phase runs
  // with no idling on either side.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] setting;
    int               phase;
    int               n;
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       setting = CFG_W'(63);
        2:       setting = CFG_W'(32);
        3:       setting = CFG_W'(0);
        4:       setting = CFG_W'($urandom_range(62, 33));
        default: setting = CFG_W'($urandom_range(31, 1));
      endcase
      wait_idle();
      set_steady(phase == 5);
      write_max_entries(setting);
      for (n = 0; n < 34; n++) begin
        if ($urandom_range(99) < 12)
          offer_item(OP_PRUNE, {$urandom, $urandom}, {$urandom, $urandom});
        else
          offer_item(OP_NOTICE, pick_key(), pick_stamp());
      end
    end
    wait_idle();
    set_steady(1'b0);
  endtask

  // The receiver stops for a long stretch while the sender keeps offering without
  // gaps, so the block backs up and holds its input; then the sender waits for the
  // whole backlog to drain.
  task automatic test_backpressure();
    int n;
    wait_idle();
    write_max_entries(CFG_W'(3));
    @(posedge clk_i);
    hold_requests++;
    @(negedge clk_i);
    sender_gaps_on = 1'b0;
    for (n = 0; n < 10; n++) offer_item(OP_NOTICE, pick_key(), pick_stamp());
    offer_item(OP_PRUNE, '0, '0);
    sender_gaps_on = 1'b1;
    wait_idle();
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_full_table();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    $display("Covered %0d notices (%0d inserted, %0d refreshed, %0d dropped) and %0d prunes",
             notices_sent, inserts_seen, updates_seen, drops_seen, prunes_sent);
    $display("with %0d keys evicted, %0d prunes with nothing to evict, %0d register writes",
             evictions, empty_prunes, configs_done);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
